// ----- rtl/lbe_pkg.sv -----
// Package for the bounded list engine: request codes and fixed field widths.
// No dependencies; used by bounded_list_engine_unit.
`default_nettype none

package lbe_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 8;
  localparam int unsigned REQ_W = 2;

  typedef logic [REQ_W-1:0] req_t;

  localparam req_t REQ_FRONT  = 2'd0;
  localparam req_t REQ_BACK   = 2'd1;
  localparam req_t REQ_DELETE = 2'd2;
  localparam req_t REQ_NONE   = 2'd3;

endpackage : lbe_pkg

`default_nettype wire

// ----- rtl/bounded_list_engine_unit.sv -----
// Bounded list engine top level: sequencer around one list RAM.
// Depends on lbe_pkg and lbe_ram.
//
// Usage. A request (in_req_type, in_item_value, in_position) is taken on the
// edge where start is high and busy is low. Insert at front, append at back,
// or delete at a position; then the whole list is dumped front to back, one
// beat per cycle on out_* marked by out_strobe, the final beat with
// out_last_entry. An empty list gives a single beat with out_list_empty set
// and out_entry_value zero. out_insert_dropped is set on every beat of a dump
// whose insert found the list full. The unused request code is ignored.
// Sequencing: the list lives in one RAM with registered read. An insert at front
// moves N entries (N = count) at one per cycle in S_SHIFT, then passes S_DRAIN
// and writes the new item in S_PUT; a delete moves the entries behind the
// position likewise, then passes S_DRAIN. The dump reads the entries front to
// back, the last beat leaving the cycle after the final read. The longest
// request is an insert at front into a list of CAPACITY-1 entries.
// Reset clears the count (empty list); RAM contents are not cleared and are
// never read before being written. The receiver cannot stall: beats are not
// held.
`default_nettype none

module bounded_list_engine_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [lbe_pkg::REQ_W-1:0]   in_req_type,
  input  wire logic signed [lbe_pkg::VAL_W-1:0] in_item_value,
  input  wire logic [lbe_pkg::POS_W-1:0]   in_position,
  output logic                             out_strobe,
  output logic signed [lbe_pkg::VAL_W-1:0] out_entry_value,
  output logic                             out_last_entry,
  output logic                             out_list_empty,
  output logic                             out_insert_dropped
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = lbe_pkg::POS_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_DUMP
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic                      up_r, up_nxt;
  logic                      pend_r, pend_nxt;
  logic [AW-1:0]             pend_addr_r, pend_addr_nxt;
  logic [lbe_pkg::VAL_W-1:0] val_r, val_nxt;
  logic                      drop_r, drop_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_empty_r, out_empty_nxt;
  logic                      out_drop_r, out_drop_nxt;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [lbe_pkg::VAL_W-1:0] ram_wdata;
  logic [lbe_pkg::VAL_W-1:0] ram_rdata;

  logic                      full;
  logic                      idx_is_tail;

  assign full        = (count_r == CW'(CAPACITY));
  assign idx_is_tail = ((CW'(idx_r) + CW'(1)) == count_r);

  // pending shift write takes the port; otherwise the single put
  assign ram_we    = pend_r || (state_r == S_PUT);
  assign ram_waddr = pend_r ? pend_addr_r : idx_r;
  assign ram_wdata = pend_r ? ram_rdata : val_r;

  lbe_ram #(
    .WIDTH (lbe_pkg::VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    up_nxt        = up_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    val_nxt       = val_r;
    drop_nxt      = drop_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_drop_nxt  = out_drop_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          val_nxt  = in_item_value;
          drop_nxt = 1'b0;
          case (in_req_type)
            lbe_pkg::REQ_FRONT: begin
              if (full) begin
                drop_nxt  = 1'b1;
                idx_nxt   = '0;
                state_nxt = S_DUMP;
              end else if (count_r == '0) begin
                idx_nxt   = '0;
                state_nxt = S_PUT;
              end else begin
                idx_nxt   = AW'(count_r - CW'(1));
                up_nxt    = 1'b1;
                state_nxt = S_SHIFT;
              end
            end
            lbe_pkg::REQ_BACK: begin
              if (full) begin
                drop_nxt  = 1'b1;
                idx_nxt   = '0;
                state_nxt = S_DUMP;
              end else begin
                idx_nxt   = AW'(count_r);
                state_nxt = S_PUT;
              end
            end
            lbe_pkg::REQ_DELETE: begin
              idx_nxt   = '0;
              state_nxt = S_DUMP;
              if ({1'b0, in_position} < PW'(count_r)) begin
                if (({1'b0, in_position} + PW'(1)) < PW'(count_r)) begin
                  idx_nxt   = AW'({1'b0, in_position} + PW'(1));
                  up_nxt    = 1'b0;
                  state_nxt = S_SHIFT;
                end else begin
                  count_nxt = count_r - CW'(1);
                end
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // read entry idx now, write it one slot over next cycle
        pend_nxt = 1'b1;
        if (up_r) begin
          pend_addr_nxt = idx_r + AW'(1);
          if (idx_r == '0) begin
            state_nxt = S_DRAIN;
          end else begin
            idx_nxt = idx_r - AW'(1);
          end
        end else begin
          pend_addr_nxt = idx_r - AW'(1);
          if (idx_is_tail) begin
            state_nxt = S_DRAIN;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end

      S_DRAIN: begin
        idx_nxt = '0;
        if (up_r) begin
          state_nxt = S_PUT;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DUMP;
        end
      end

      S_PUT: begin
        count_nxt = count_r + CW'(1);
        idx_nxt   = '0;
        state_nxt = S_DUMP;
      end

      S_DUMP: begin
        out_valid_nxt = 1'b1;
        out_drop_nxt  = drop_r;
        if (count_r == '0) begin
          out_empty_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          out_empty_nxt = 1'b0;
          out_last_nxt  = idx_is_tail;
          if (idx_is_tail) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      up_r        <= 1'b0;
      pend_r      <= 1'b0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_empty_r <= 1'b0;
      out_drop_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      up_r        <= up_nxt;
      pend_r      <= pend_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      out_empty_r <= out_empty_nxt;
      out_drop_r  <= out_drop_nxt;
    end
    pend_addr_r <= pend_addr_nxt;
    val_r       <= val_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_strobe         = out_valid_r;
  assign out_entry_value    = out_empty_r ? '0 : signed'(ram_rdata);
  assign out_last_entry     = out_last_r;
  assign out_list_empty     = out_empty_r;
  assign out_insert_dropped = out_drop_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("list count above capacity");

  a_dump_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> !ram_we)
    else $error("RAM written during dump");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_r && (state_r == S_PUT)))
    else $error("shift write and put collide");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> out_last_r)
    else $error("empty beat without last mark");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type != lbe_pkg::REQ_NONE)) |=> busy)
    else $error("accepted request did not start");

endmodule : bounded_list_engine_unit

`default_nettype wire

// ----- rtl/lbe_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lbe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : lbe_ram

`default_nettype wire
